>>> hdl/xcdm_pkg.sv
// Package for the XOR crib-drag matcher: command codes, cell control struct
// and the letter-or-space test. No dependencies.
package xcdm_pkg;

    localparam int BYTE_W   = 8;
    localparam int CMD_W    = 2;
    localparam int OFFSET_W = 16;

    localparam logic [BYTE_W-1:0] SPACE_CHAR = 8'h20;
    localparam logic [BYTE_W-1:0] UPPER_LO   = 8'h41;
    localparam logic [BYTE_W-1:0] UPPER_HI   = 8'h5A;
    localparam logic [BYTE_W-1:0] LOWER_LO   = 8'h61;
    localparam logic [BYTE_W-1:0] LOWER_HI   = 8'h7A;

    // input word commands; the fourth code is unused and ignored
    typedef enum logic [CMD_W-1:0] {
        CMD_NEW  = 2'd0,
        CMD_CRIB = 2'd1,
        CMD_PAIR = 2'd2
    } xcdm_cmd_t;

    // per-cycle control broadcast to every cell
    typedef struct packed {
        logic clear;       // new search: drop all crib bytes
        logic crib_shift;  // push a crib byte in at cell 0
        logic pair_shift;  // push an XOR byte in at cell 0 and re-test
    } xcdm_ctrl_t;

    function automatic logic is_letter_or_space(input logic [BYTE_W-1:0] c);
        logic res;
        res = (c == SPACE_CHAR)
            || ((c >= UPPER_LO) && (c <= UPPER_HI))
            || ((c >= LOWER_LO) && (c <= LOWER_HI));
        return res;
    endfunction

endpackage

>>> hdl/xor_crib_drag_matcher_core.sv
// Top level of the XOR crib-drag matcher: command decode, counters, the
// cell chain and the result/output stages. Depends on xcdm_pkg, xcdm_cell.
//
// Usage
//   Input channel (s_*): one word per command. CMD_NEW clears the crib and
//   the position counter, CMD_CRIB appends s_crib_byte to the crib (bytes
//   past MAX_CRIB are dropped), CMD_PAIR XORs s_cipher_a with s_cipher_b and
//   shifts the byte into the window. Once a crib is loaded and at least
//   crib-length pairs have been taken, each pair yields one result word on
//   the m_* channel: the start offset of the tested alignment and whether
//   every decoded byte is a letter or a space. Other commands give no result.
//   Throughput: one input word per cycle while s_ready is high. Each cell of
//   the chain tests its own crib/window byte pair as the window shifts, so a
//   full alignment is checked with every pair; the per-cell flags are then
//   AND-reduced. Path: a pair's test is registered in the cells and the
//   result stage, then in the output register, before it shows on m_valid.
//   Stall: while m_ready is low a finished result waits in the output
//   register and one more can wait in the result stage; s_ready drops only
//   when both are full.
//   Reset: aresetn (synchronous, active low) empties the crib, zeroes the
//   counters and drops any pending results. No clearing pass is needed.
module xor_crib_drag_matcher_core
    import xcdm_pkg::*;
#(
    parameter int MAX_CRIB   = 64,
    parameter int MAX_STREAM = 65536
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [CMD_W-1:0]    s_cmd,
    input  logic [BYTE_W-1:0]   s_crib_byte,
    input  logic [BYTE_W-1:0]   s_cipher_a,
    input  logic [BYTE_W-1:0]   s_cipher_b,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [OFFSET_W-1:0] m_offset,
    output logic                m_match
);

    localparam int LEN_W = $clog2(MAX_CRIB + 1);
    localparam int CNT_W = $clog2(MAX_STREAM + 1);
    localparam int CMP_W = (LEN_W > CNT_W) ? LEN_W : CNT_W;

    xcdm_ctrl_t ctrl;
    logic       accept;
    logic       out_free;
    logic       s1_move;
    logic       hit;

    logic [LEN_W-1:0]    len_reg, len_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [CNT_W-1:0]    cnt_inc;
    logic [CMP_W-1:0]    diff;

    logic                s1_v_reg, s1_v_next;
    logic [OFFSET_W-1:0] s1_off_reg;
    logic                m_valid_reg, m_valid_next;
    logic [OFFSET_W-1:0] m_offset_reg;
    logic                m_match_reg;

    logic [BYTE_W-1:0]   crib_link [MAX_CRIB];
    logic                vld_link  [MAX_CRIB];
    logic [BYTE_W-1:0]   win_link  [MAX_CRIB];
    logic [MAX_CRIB-1:0] ok_vec;
    logic [BYTE_W-1:0]   xor_byte;

    // handshake: stall only when the result stage and output are both full
    assign out_free = !m_valid_reg || m_ready;
    assign s1_move  = s1_v_reg && out_free;
    assign s_ready  = !s1_v_reg || out_free;
    assign accept   = s_valid && s_ready;

    // command decode
    always_comb begin
        ctrl = '0;
        if (accept) begin
            unique case (s_cmd)
                CMD_NEW:  ctrl.clear      = 1'b1;
                CMD_CRIB: ctrl.crib_shift = (len_reg < LEN_W'(MAX_CRIB));
                CMD_PAIR: ctrl.pair_shift = (cnt_reg < CNT_W'(MAX_STREAM));
                default:  ctrl = '0;
            endcase
        end
    end

    // crib length and pair counter
    assign cnt_inc = cnt_reg + CNT_W'(1);
    assign diff    = CMP_W'(cnt_inc) - CMP_W'(len_reg);
    assign hit     = ctrl.pair_shift && (len_reg != '0)
                     && (CMP_W'(cnt_inc) >= CMP_W'(len_reg));

    always_comb begin
        len_next = len_reg;
        cnt_next = cnt_reg;
        if (ctrl.clear) begin
            len_next = '0;
            cnt_next = '0;
        end else begin
            if (ctrl.crib_shift) begin
                len_next = len_reg + LEN_W'(1);
            end
            if (ctrl.pair_shift) begin
                cnt_next = cnt_inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg <= '0;
            cnt_reg <= '0;
        end else begin
            len_reg <= len_next;
            cnt_reg <= cnt_next;
        end
    end

    // cell chain: cell 0 takes the newest bytes, older ones move outward
    assign xor_byte = s_cipher_a ^ s_cipher_b;

    for (genvar j = 0; j < MAX_CRIB; j++) begin : g_cell
        logic [BYTE_W-1:0] crib_src;
        logic              vld_src;
        logic [BYTE_W-1:0] win_src;

        if (j == 0) begin : g_head
            assign crib_src = s_crib_byte;
            assign vld_src  = 1'b1;
            assign win_src  = xor_byte;
        end else begin : g_body
            assign crib_src = crib_link[j-1];
            assign vld_src  = vld_link[j-1];
            assign win_src  = win_link[j-1];
        end

        xcdm_cell u_cell (
            .aclk         (aclk),
            .aresetn      (aresetn),
            .ctrl         (ctrl),
            .crib_in      (crib_src),
            .crib_vld_in  (vld_src),
            .win_in       (win_src),
            .crib_out     (crib_link[j]),
            .crib_vld_out (vld_link[j]),
            .win_out      (win_link[j]),
            .ok           (ok_vec[j])
        );
    end

    // result stage: holds the offset while the cells hold their test flags
    always_comb begin
        s1_v_next = s1_v_reg;
        if (hit) begin
            s1_v_next = 1'b1;
        end else if (s1_move) begin
            s1_v_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_v_reg <= 1'b0;
        end else begin
            s1_v_reg <= s1_v_next;
        end
        if (hit) begin
            s1_off_reg <= OFFSET_W'(diff);
        end
    end

    // output register: AND-reduce the cell flags as the word moves out
    always_comb begin
        m_valid_next = m_valid_reg;
        if (s1_move) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        if (s1_move) begin
            m_offset_reg <= s1_off_reg;
            m_match_reg  <= &ok_vec;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_offset = m_offset_reg;
    assign m_match  = m_match_reg;

endmodule

>>> hdl/xcdm_cell.sv
// One cell of the crib-drag chain: holds one crib byte, one window byte and
// the registered decode test of that pair. Depends on xcdm_pkg.
module xcdm_cell
    import xcdm_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  xcdm_ctrl_t        ctrl,
    input  logic [BYTE_W-1:0] crib_in,
    input  logic              crib_vld_in,
    input  logic [BYTE_W-1:0] win_in,
    output logic [BYTE_W-1:0] crib_out,
    output logic              crib_vld_out,
    output logic [BYTE_W-1:0] win_out,
    output logic              ok
);

    logic [BYTE_W-1:0] crib_reg;
    logic              crib_vld_reg;
    logic [BYTE_W-1:0] win_reg;
    logic              ok_reg;
    logic              ok_next;

    // an unused crib slot always passes; otherwise decode against the new byte
    assign ok_next = !crib_vld_reg || is_letter_or_space(crib_reg ^ win_in);

    // crib valid flag: control state
    always_ff @(posedge aclk) begin
        if (!aresetn || ctrl.clear) begin
            crib_vld_reg <= 1'b0;
        end else if (ctrl.crib_shift) begin
            crib_vld_reg <= crib_vld_in;
        end
    end

    // payload shift stages
    always_ff @(posedge aclk) begin
        if (ctrl.crib_shift) begin
            crib_reg <= crib_in;
        end
        if (ctrl.pair_shift) begin
            win_reg <= win_in;
            ok_reg  <= ok_next;
        end
    end

    assign crib_out     = crib_reg;
    assign crib_vld_out = crib_vld_reg;
    assign win_out      = win_reg;
    assign ok           = ok_reg;

endmodule

>>> hdl/xcdm_checker.sv
// Port-level checks for the XOR crib-drag matcher, bound to the top level.
// Depends on xcdm_pkg and xor_crib_drag_matcher_core.
module xcdm_checker
    import xcdm_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic [CMD_W-1:0]    s_cmd,
    input logic                m_valid,
    input logic                m_ready,
    input logic [OFFSET_W-1:0] m_offset,
    input logic                m_match
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_offset) && $stable(m_match))
        else $error("result word changed while stalled");

    // reset empties the output
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // input is only held off by a stalled output
    a_ready_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled without output backpressure");

    // a fresh result comes from a ciphertext pair that went through the result stage
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready && (s_cmd == CMD_PAIR), 2))
        else $error("result without a preceding ciphertext pair");

endmodule

bind xor_crib_drag_matcher_core xcdm_checker u_xcdm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_valid  (s_valid),
    .s_ready  (s_ready),
    .s_cmd    (s_cmd),
    .m_valid  (m_valid),
    .m_ready  (m_ready),
    .m_offset (m_offset),
    .m_match  (m_match)
);

>>> bench/tb_xor_crib_drag_matcher_core.sv
// Self-checking bench for xor_crib_drag_matcher_core: directed and random crib-drag
// searches, random gaps and stalls on both channels.
// Depends on xcdm_pkg and the core RTL.
module tb_xor_crib_drag_matcher_core
    import xcdm_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CRIB_DEPTH   = 64;
    localparam int STREAM_LIMIT = 65536;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_WORDS = 870;
    localparam int MAX_REPORTS  = 10;

    // the fourth command code, which the core ignores
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    // one input word plus the idle cycles to leave before offering it
    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [BYTE_W-1:0] crib;
        logic [BYTE_W-1:0] ca;
        logic [BYTE_W-1:0] cb;
        int                gap;
    } drive_word_t;

    typedef struct packed {
        logic [OFFSET_W-1:0] offset;
        logic                match;
    } alignment_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [CMD_W-1:0]    s_cmd = '0;
    logic [BYTE_W-1:0]   s_crib_byte = '0;
    logic [BYTE_W-1:0]   s_cipher_a = '0;
    logic [BYTE_W-1:0]   s_cipher_b = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [OFFSET_W-1:0] m_offset;
    logic                m_match;

    xor_crib_drag_matcher_core #(
        .MAX_CRIB   (CRIB_DEPTH),
        .MAX_STREAM (STREAM_LIMIT)
    ) DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_cmd       (s_cmd),
        .s_crib_byte (s_crib_byte),
        .s_cipher_a  (s_cipher_a),
        .s_cipher_b  (s_cipher_b),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_offset    (m_offset),
        .m_match     (m_match)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    drive_word_t pending_words[$];
    alignment_t  expected_alignments[$];

    int gap_max = 0;
    int stim_count = 0;
    int words_taken = 0;
    int results_checked = 0;
    int matches_seen = 0;
    int mismatch_count = 0;
    int cycle_count = 0;

    // predictor state: crib, XOR history (newest at the top) and pair count
    logic [BYTE_W-1:0] crib_bytes[CRIB_DEPTH];
    logic [BYTE_W-1:0] xor_hist[CRIB_DEPTH];
    int crib_len = 0;
    int pairs_seen = 0;

    function automatic logic is_text_byte(input logic [BYTE_W-1:0] c);
        return (c == 8'h20) || (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic logic [BYTE_W-1:0] text_char();
        int r;
        r = $urandom_range(0, 52);
        if (r == 52) return SPACE_CHAR;
        if (r < 26) return 8'(8'h41 + r);
        return 8'(8'h61 + r - 26);
    endfunction

    // advance the predictor by one accepted word, queueing any alignment it tests
    task automatic drag_step(input drive_word_t w);
        logic       all_text;
        int         base;
        alignment_t exp_word;
        case (w.cmd)
            CMD_NEW: begin
                crib_len = 0;
                pairs_seen = 0;
                for (int i = 0; i < CRIB_DEPTH; i++) begin
                    crib_bytes[i] = '0;
                    xor_hist[i] = '0;
                end
            end
            CMD_CRIB: begin
                if (crib_len < CRIB_DEPTH) begin
                    crib_bytes[crib_len] = w.crib;
                    crib_len++;
                end
            end
            CMD_PAIR: begin
                if (pairs_seen < STREAM_LIMIT) begin
                    for (int i = 0; i < CRIB_DEPTH - 1; i++) xor_hist[i] = xor_hist[i + 1];
                    xor_hist[CRIB_DEPTH - 1] = w.ca ^ w.cb;
                    pairs_seen++;
                    if (crib_len != 0 && pairs_seen >= crib_len) begin
                        base = CRIB_DEPTH - crib_len;
                        all_text = 1'b1;
                        for (int i = 0; i < crib_len; i++) begin
                            if (!is_text_byte(crib_bytes[i] ^ xor_hist[base + i]))
                                all_text = 1'b0;
                        end
                        exp_word.offset = OFFSET_W'(pairs_seen - crib_len);
                        exp_word.match  = all_text;
                        expected_alignments = {expected_alignments, exp_word};
                    end
                end
            end
            default: ;
        endcase
    endtask

    task automatic add_word(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] crib,
                            input logic [BYTE_W-1:0] ca, input logic [BYTE_W-1:0] cb);
        drive_word_t w;
        w.cmd = cmd;
        w.crib = crib;
        w.ca = ca;
        w.cb = cb;
        w.gap = $urandom_range(0, gap_max);
        pending_words = {pending_words, w};
        if (cmd != CMD_UNUSED) stim_count++;
    endtask

    // one search: plaintexts of letters and spaces under a shared key stream,
    // crib mostly lifted from the first plaintext so one alignment should match
    task automatic add_random_search();
        logic [BYTE_W-1:0] plain_a[128];
        logic [BYTE_W-1:0] plain_b[128];
        logic [BYTE_W-1:0] key;
        int len;
        int n_pairs;
        int start;
        int pick;
        int grow_at;
        logic random_crib;
        pick = $urandom_range(0, 99);
        if (pick < 5) len = 0;
        else if (pick < 12) len = $urandom_range(60, 68);
        else len = $urandom_range(1, 8);
        if ($urandom_range(0, 9) == 0) n_pairs = $urandom_range(0, len);
        else n_pairs = len + $urandom_range(1, 20);
        for (int i = 0; i < 128; i++) begin
            plain_a[i] = text_char();
            plain_b[i] = text_char();
        end
        start = (n_pairs >= len) ? $urandom_range(0, n_pairs - len) : 0;
        random_crib = ($urandom_range(0, 4) == 0);
        grow_at = ($urandom_range(0, 9) == 0) ? n_pairs / 2 : -1;
        add_word(CMD_NEW, 8'($urandom), 8'($urandom), 8'($urandom));
        for (int i = 0; i < len; i++)
            add_word(CMD_CRIB, random_crib ? 8'($urandom) : plain_a[start + i],
                     8'($urandom), 8'($urandom));
        for (int i = 0; i < n_pairs; i++) begin
            if (i == grow_at) add_word(CMD_CRIB, text_char(), 8'($urandom), 8'($urandom));
            key = 8'($urandom);
            add_word(CMD_PAIR, 8'($urandom), plain_a[i] ^ key, plain_b[i] ^ key);
        end
    endtask

    task automatic add_noise();
        int n;
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++)
            add_word(2'($urandom_range(0, 3)), 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    // directed words: empty crib, ignored code, letter boundaries, growth, short stream
    task automatic add_directed();
        gap_max = 2;
        add_word(CMD_NEW, 8'h00, 8'h00, 8'h00);
        add_word(CMD_PAIR, 8'h00, 8'hFF, 8'h00);
        add_word(CMD_UNUSED, 8'hFF, 8'hFF, 8'hFF);
        add_word(CMD_CRIB, 8'h20, 8'h00, 8'h00);
        add_word(CMD_PAIR, 8'h00, 8'h00, 8'h00);
        add_word(CMD_PAIR, 8'hFF, 8'hFF, 8'hFF);
        add_word(CMD_PAIR, 8'h00, 8'h61, 8'h00);
        add_word(CMD_PAIR, 8'h00, 8'hA0, 8'h00);
        add_word(CMD_CRIB, 8'hFF, 8'h00, 8'h00);
        add_word(CMD_PAIR, 8'h00, 8'h00, 8'h9E);
        add_word(CMD_NEW, 8'hFF, 8'hFF, 8'hFF);
        add_word(CMD_CRIB, 8'h00, 8'h00, 8'h00);
        add_word(CMD_PAIR, 8'h00, 8'h40, 8'h00);
        add_word(CMD_PAIR, 8'h00, 8'h00, 8'h41);
        add_word(CMD_PAIR, 8'h00, 8'hFF, 8'hA5);
        add_word(CMD_PAIR, 8'h00, 8'h5B, 8'h00);
        add_word(CMD_PAIR, 8'h00, 8'h60, 8'h00);
        add_word(CMD_PAIR, 8'h00, 8'h7A, 8'h00);
        add_word(CMD_PAIR, 8'h00, 8'h7B, 8'h00);
        add_word(CMD_PAIR, 8'h00, 8'h1F, 8'h00);
        add_word(CMD_NEW, 8'h00, 8'h00, 8'h00);
        add_word(CMD_CRIB, 8'h48, 8'h00, 8'h00);
        add_word(CMD_CRIB, 8'h69, 8'h00, 8'h00);
        add_word(CMD_PAIR, 8'h00, 8'h12, 8'h12);
        add_word(CMD_PAIR, 8'h00, 8'h49, 8'h00);
    endtask

    // driver: pops the next word, idles for its gap, then holds it until taken
    drive_word_t cur_word = '0;
    logic word_staged = 1'b0;
    logic word_held = 1'b0;
    int   idle_left = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            cur_word = '0;
            word_staged = 1'b0;
            word_held = 1'b0;
            idle_left = 0;
        end else begin
            if (s_valid && s_ready) begin
                drag_step(cur_word);
                words_taken++;
                word_held = 1'b0;
            end
            if (!word_held && !word_staged && pending_words.size() != 0) begin
                cur_word = pending_words.pop_front();
                idle_left = cur_word.gap;
                word_staged = 1'b1;
            end
            if (word_staged) begin
                if (idle_left > 0) begin
                    idle_left--;
                end else begin
                    word_staged = 1'b0;
                    word_held = 1'b1;
                end
            end
            s_valid     <= word_held;
            s_cmd       <= cur_word.cmd;
            s_crib_byte <= cur_word.crib;
            s_cipher_a  <= cur_word.ca;
            s_cipher_b  <= cur_word.cb;
        end
    end

    // monitor: checks each result word, stalls a drawn number of cycles after it
    int stall_left = 0;
    int stall_max = 15;

    always @(posedge aclk) begin
        alignment_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_valid && m_ready) begin
                results_checked++;
                if (m_match) matches_seen++;
                if (expected_alignments.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("unexpected result: offset %0d match %0b", m_offset, m_match);
                end else begin
                    want = expected_alignments.pop_front();
                    if (m_offset !== want.offset || m_match !== want.match) begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                            $display("result %0d: offset exp %0d got %0d, match exp %0b got %0b",
                                     results_checked, want.offset, m_offset, want.match,
                                     m_match);
                    end
                end
                // switch between no stalls, short and long stalls now and then
                if (results_checked % 40 == 0) begin
                    case ($urandom_range(0, 2))
                        0: stall_max = 0;
                        1: stall_max = 3;
                        default: stall_max = 15;
                    endcase
                end
                stall_left = $urandom_range(0, stall_max);
            end else if (stall_left > 0) begin
                stall_left--;
            end
            m_ready <= (stall_left == 0);
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("xor_crib_drag_matcher_core test failed");
            $finish;
        end
    end

    initial begin
        int random_base;
        add_directed();
        random_base = stim_count;
        while (stim_count - random_base < RANDOM_WORDS) begin
            // occasionally change the sender's idling for the next stretch
            if ($urandom_range(0, 7) == 0) begin
                case ($urandom_range(0, 2))
                    0: gap_max = 0;
                    1: gap_max = 3;
                    default: gap_max = 15;
                endcase
            end
            if ($urandom_range(0, 99) < 85) add_random_search();
            else add_noise();
        end

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_words.size() != 0 || word_staged || word_held) @(posedge aclk);
        while (expected_alignments.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("%0d input words taken, %0d results checked (%0d matching alignments)",
                 words_taken, results_checked, matches_seen);
        $display("%0d mismatches, %0d results still outstanding",
                 mismatch_count, expected_alignments.size());
        if (mismatch_count == 0 && expected_alignments.size() == 0) begin
            $display("xor_crib_drag_matcher_core test passed");
        end else begin
            $display("xor_crib_drag_matcher_core test failed");
        end
        $finish;
    end

endmodule
